// ===== rtl/core/sync_length_xor_frame_receiver_assert.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Next-cycle implication, checked out of reset.
`define SLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

// ===== rtl/core/slfr_pkg.sv =====
`default_nettype none

package slfr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 256;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    typedef enum logic [1:0] {
        OP_RX      = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_BADSUM   = 3'd2,
        EV_OVERSIZE = 3'd3,
        EV_DISCARD  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        PS_SYNC1,
        PS_SYNC2,
        PS_TYPE,
        PS_LENH,
        PS_LENL,
        PS_CHECK,
        PS_DATA
    } parse_state_t;

    // Per-word status from the parser, already reflecting the word's update.
    typedef struct packed {
        event_t      event_status;
        logic        frame_held;
        logic [7:0]  held_type;
        logic [8:0]  held_length;
        logic [31:0] good_frames;
        logic        rd_en;
    } slfr_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/slfr_parser.sv =====
`default_nettype none

module slfr_parser #(
    parameter int unsigned MAX_PAYLOAD = 256,
    parameter int unsigned LW          = 9,
    parameter int unsigned AW          = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire logic [1:0]           opcode,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [7:0]           read_index,
    output slfr_pkg::slfr_status_t    status,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [7:0]                wr_data,
    output logic [AW-1:0]             rd_addr
);
    import slfr_pkg::*;

    localparam int unsigned CW = (LW > 8) ? LW : 8;
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_PAYLOAD);
    localparam logic [15:0]   MAX_LEN = 16'(MAX_PAYLOAD);

    parse_state_t state_reg, state_next;

    logic [7:0]    type_reg, type_next;
    logic [7:0]    len_hi_reg, len_hi_next;
    logic [LW-1:0] frame_len_reg, frame_len_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [7:0]    run_xor_reg, run_xor_next;
    logic [7:0]    exp_xor_reg, exp_xor_next;
    logic          held_reg, held_next;
    logic [7:0]    held_type_reg, held_type_next;
    logic [LW-1:0] held_len_reg, held_len_next;
    logic [31:0]   count_reg, count_next;

    event_t        ev;
    logic          finish;
    logic [7:0]    fin_run;
    logic [7:0]    fin_exp;
    logic [15:0]   len_full;
    logic [LW-1:0] pos_inc;
    logic          rd_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PS_SYNC1;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        type_next      = type_reg;
        len_hi_next    = len_hi_reg;
        frame_len_next = frame_len_reg;
        pos_next       = pos_reg;
        run_xor_next   = run_xor_reg;
        exp_xor_next   = exp_xor_reg;
        held_next      = held_reg;
        held_type_next = held_type_reg;
        held_len_next  = held_len_reg;
        count_next     = count_reg;
        ev             = EV_NONE;
        finish         = 1'b0;
        fin_run        = run_xor_reg;
        fin_exp        = exp_xor_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        len_full       = {len_hi_reg, rx_byte};
        pos_inc        = pos_reg + 1'b1;

        if (accept) begin
            unique case (opcode)
                OP_RX: begin
                    unique case (state_reg)
                        PS_SYNC1: begin
                            if (rx_byte == SYNC_FIRST) begin
                                state_next = PS_SYNC2;
                            end
                        end
                        PS_SYNC2: begin
                            state_next = (rx_byte == SYNC_SECOND) ? PS_TYPE : PS_SYNC1;
                        end
                        PS_TYPE: begin
                            type_next    = rx_byte;
                            run_xor_next = rx_byte;
                            state_next   = PS_LENH;
                        end
                        PS_LENH: begin
                            len_hi_next  = rx_byte;
                            run_xor_next = run_xor_reg ^ rx_byte;
                            state_next   = PS_LENL;
                        end
                        PS_LENL: begin
                            run_xor_next   = run_xor_reg ^ rx_byte;
                            pos_next       = '0;
                            frame_len_next = LW'(len_full);
                            if (len_full > MAX_LEN) begin
                                state_next = PS_SYNC1;
                                ev         = EV_OVERSIZE;
                            end else begin
                                state_next = PS_CHECK;
                            end
                        end
                        PS_CHECK: begin
                            exp_xor_next = rx_byte;
                            if (frame_len_reg == '0) begin
                                finish  = 1'b1;
                                fin_exp = rx_byte;
                            end else begin
                                state_next = PS_DATA;
                            end
                        end
                        PS_DATA: begin
                            run_xor_next = run_xor_reg ^ rx_byte;
                            fin_run      = run_xor_reg ^ rx_byte;
                            wr_en        = !held_reg;
                            pos_next     = pos_inc;
                            if (pos_inc == frame_len_reg) begin
                                finish = 1'b1;
                            end
                        end
                        default: begin
                            state_next = PS_SYNC1;
                        end
                    endcase
                end
                OP_READ: begin
                    rd_en = held_reg && (CW'(read_index) < CW'(held_len_reg))
                            && (CW'(read_index) < MAX_C);
                end
                OP_RELEASE: begin
                    held_next = 1'b0;
                end
                default: begin
                end
            endcase

            // Close the frame: check the sum, then take it unless one is held.
            if (finish) begin
                state_next = PS_SYNC1;
                if (fin_run != fin_exp) begin
                    ev = EV_BADSUM;
                end else if (held_reg) begin
                    ev = EV_DISCARD;
                end else begin
                    ev             = EV_GOOD;
                    held_next      = 1'b1;
                    held_type_next = type_reg;
                    held_len_next  = frame_len_reg;
                    count_next     = count_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        type_reg      <= type_next;
        len_hi_reg    <= len_hi_next;
        frame_len_reg <= frame_len_next;
        pos_reg       <= pos_next;
        run_xor_reg   <= run_xor_next;
        exp_xor_reg   <= exp_xor_next;
        held_type_reg <= held_type_next;
        held_len_reg  <= held_len_next;
        if (!aresetn) begin
            held_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    assign wr_addr = pos_reg[AW-1:0];
    assign wr_data = rx_byte;
    assign rd_addr = AW'(read_index);

    assign status.event_status = ev;
    assign status.frame_held   = held_next;
    assign status.held_type    = held_next ? held_type_next : 8'd0;
    assign status.held_length  = held_next ? 9'(held_len_next) : 9'd0;
    assign status.good_frames  = count_next;
    assign status.rd_en        = rd_en;

`include "sync_length_xor_frame_receiver_assert.svh"

    `SLFR_ASSERT_NOW(a_no_write_while_held, aclk, aresetn, wr_en, !held_reg)
    `SLFR_ASSERT_NEXT(a_good_takes_frame, aclk, aresetn, accept && (ev == EV_GOOD),
        held_reg && (count_reg == $past(count_reg) + 32'd1))
    `SLFR_ASSERT_NOW(a_discard_only_held, aclk, aresetn, accept && (ev == EV_DISCARD),
        held_reg && held_next)

endmodule

`default_nettype wire

// ===== rtl/core/sync_length_xor_frame_receiver.sv =====
// Pipeline: an accepted word's status is registered in stage one, beside the
// registered buffer read, and moves on to the output register when that is free.
// Throughput: one word per cycle while the output register is free or being taken;
// the parser drives the single-port payload buffer write and the registered buffer read.
// Reset: synchronous, active low; parser back to first sync, nothing held,
// frame count zero. The payload buffer is not cleared: reads are gated by held length.
`default_nettype none

module sync_length_xor_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic [7:0]  s_read_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_status,
    output logic             m_frame_held,
    output logic [7:0]       m_held_type,
    output logic [8:0]       m_held_length,
    output logic [7:0]       m_read_data,
    output logic [31:0]      m_good_frames
);
    import slfr_pkg::*;

    // Length needs to hold MAX_PAYLOAD itself; the buffer address only its entries.
    localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic          accept;
    slfr_status_t  status;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;

    // Payload buffer: written by the parser while nothing is held, read by
    // the read opcode only while a frame is held, so a word never reads and
    // writes the buffer at once. A write at one edge is seen by a read at the next.
    logic [7:0] payload_mem [MAX_PAYLOAD];
    logic [7:0] mem_rdata_reg;

    // Stage one: status of the accepted word, waiting for the buffer data.
    logic         s1_valid_reg, s1_valid_next;
    slfr_status_t s1_status_reg;
    logic         s1_adv;

    // Output register.
    logic         m_valid_reg, m_valid_next;
    slfr_status_t m_status_reg;
    logic [7:0]   m_rdata_reg;

    // Stage one moves on whenever the output register is free or being taken;
    // a new word enters whenever stage one is empty or moving on.
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    slfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LW          (LW),
        .AW          (AW)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .opcode     (s_opcode),
        .rx_byte    (s_rx_byte),
        .read_index (s_read_index),
        .status     (status),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr)
    );

    // Read only on an accepted read word, so the data holds while stage one stalls.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            payload_mem[wr_addr] <= wr_data;
        end
        if (accept && status.rd_en) begin
            mem_rdata_reg <= payload_mem[rd_addr];
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        if (accept) begin
            s1_status_reg <= status;
        end
        if (s1_adv) begin
            m_status_reg <= s1_status_reg;
            m_rdata_reg  <= s1_status_reg.rd_en ? mem_rdata_reg : 8'd0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_status = m_status_reg.event_status;
    assign m_frame_held   = m_status_reg.frame_held;
    assign m_held_type    = m_status_reg.held_type;
    assign m_held_length  = m_status_reg.held_length;
    assign m_read_data    = m_rdata_reg;
    assign m_good_frames  = m_status_reg.good_frames;

`include "sync_length_xor_frame_receiver_assert.svh"

    `SLFR_ASSERT_NOW(a_idle_fields_zero, aclk, aresetn, m_valid && !m_frame_held,
        (m_held_type == 8'd0) && (m_held_length == 9'd0))
    `SLFR_ASSERT_NOW(a_read_needs_held, aclk, aresetn, m_valid && (m_read_data != 8'd0),
        m_frame_held)
    `SLFR_ASSERT_NEXT(a_stage_moves, aclk, aresetn, s1_valid_reg && (!m_valid || m_ready),
        m_valid)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import slfr_pkg::*;

    // Opcode value the block has no action for.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int unsigned FRAME_MAX    = MAX_PAYLOAD_DEF;
    localparam int unsigned WORD_TARGET  = 550;
    localparam int          STALL_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // What one result word reports, in port order.
    typedef struct packed {
        event_t      ev;
        logic        held;
        logic [7:0]  htype;
        logic [8:0]  hlen;
        logic [7:0]  rdata;
        logic [31:0] good;
    } frame_result_t;

    // One opening word; typed rows carry their result, the rest go to the predictor.
    typedef struct packed {
        logic [1:0]    op;
        logic [7:0]    b;
        logic [7:0]    idx;
        logic          typed;
        frame_result_t want;
    } stim_row_t;

    typedef enum int unsigned {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_CUT,
        FLAW_SYNC
    } frame_flaw_t;

    localparam frame_result_t NO_STATUS = '0;

    localparam stim_row_t OPENING_ROWS [28] = '{
        // Nothing held yet: read at the top index, release and unused opcode all give zeros.
        '{OP_READ,    8'h00, 8'hFF, 1'b1, NO_STATUS},
        '{OP_RELEASE, 8'hFF, 8'h00, 1'b1, NO_STATUS},
        '{OP_UNUSED,  8'hFF, 8'hFF, 1'b1, NO_STATUS},
        // First sync byte followed by something other than the second one.
        '{OP_RX, 8'hAA, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        // Zero-length frame, closed by its checksum byte and then held.
        '{OP_RX, 8'hAA, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h55, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'hFF, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'hFF, 8'h00, 1'b1, '{EV_GOOD, 1'b1, 8'hFF, 9'd0, 8'h00, 32'd1}},
        // A second good frame while the first is held: discarded.
        '{OP_RX, 8'hAA, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h55, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b1, '{EV_DISCARD, 1'b1, 8'hFF, 9'd0, 8'h00, 32'd1}},
        // Largest length field: dropped straight after the length bytes.
        '{OP_RX, 8'hAA, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h55, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'hFF, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'hFF, 8'h00, 1'b1, '{EV_OVERSIZE, 1'b1, 8'hFF, 9'd0, 8'h00, 32'd1}},
        // Checksum mismatch still reported with a frame held.
        '{OP_RX, 8'hAA, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h55, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h00, 8'h00, 1'b0, NO_STATUS},
        '{OP_RX, 8'h01, 8'h00, 1'b1, '{EV_BADSUM, 1'b1, 8'hFF, 9'd0, 8'h00, 32'd1}}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [7:0]  s_rx_byte;
    logic [7:0]  s_read_index;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_status;
    logic        m_frame_held;
    logic [7:0]  m_held_type;
    logic [8:0]  m_held_length;
    logic [7:0]  m_read_data;
    logic [31:0] m_good_frames;

    // Predictor state: the parser, the held frame and our copy of the payload buffer.
    parse_state_t  rx_phase;
    logic [7:0]    rx_type;
    logic [15:0]   rx_length;
    logic [8:0]    rx_pos;
    logic [7:0]    rx_sum;
    logic [7:0]    rx_check;
    logic          hold_valid;
    logic [7:0]    hold_type;
    logic [8:0]    hold_len;
    logic [31:0]   frames_ok;
    logic [7:0]    shadow_buf [0:FRAME_MAX-1];
    bit            shadow_written [0:FRAME_MAX-1];

    // Status words due from the block, oldest first.
    frame_result_t status_due [$];

    int          fail_count   = 0;
    int          quiet_cycles = 0;
    int unsigned words_sent   = 0;
    bit          src_calm     = 1'b0;

    sync_length_xor_frame_receiver i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_rx_byte      (s_rx_byte),
        .s_read_index   (s_read_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_status (m_event_status),
        .m_frame_held   (m_frame_held),
        .m_held_type    (m_held_type),
        .m_held_length  (m_held_length),
        .m_read_data    (m_read_data),
        .m_good_frames  (m_good_frames)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string field, input logic [31:0] seen,
                                   input logic [31:0] due);
        fail_count++;
        // Keep the log short if the block goes badly wrong.
        if (fail_count <= 40)
            $display("%0t: %s is 0x%0h, expected 0x%0h", $time, field, seen, due);
    endtask

    // Close the frame on its last byte: checksum first, then the hold decides.
    function automatic event_t close_frame();
        rx_phase = PS_SYNC1;
        if (rx_sum != rx_check)
            return EV_BADSUM;
        if (hold_valid)
            return EV_DISCARD;
        hold_valid = 1'b1;
        hold_type  = rx_type;
        hold_len   = rx_length[8:0];
        frames_ok  = frames_ok + 32'd1;
        return EV_GOOD;
    endfunction

    // Advance the predicted receiver by one accepted word and give its status.
    function automatic frame_result_t parse_word(input logic [1:0] op, input logic [7:0] b,
                                                 input logic [7:0] idx);
        frame_result_t r;
        r = NO_STATUS;
        case (op)
            OP_RX: begin
                case (rx_phase)
                    PS_SYNC1: begin
                        if (b == SYNC_FIRST)
                            rx_phase = PS_SYNC2;
                    end
                    PS_SYNC2: begin
                        if (b == SYNC_SECOND)
                            rx_phase = PS_TYPE;
                        else
                            rx_phase = PS_SYNC1;
                    end
                    PS_TYPE: begin
                        rx_type  = b;
                        rx_sum   = b;
                        rx_phase = PS_LENH;
                    end
                    PS_LENH: begin
                        rx_length = {b, 8'h00};
                        rx_sum    = rx_sum ^ b;
                        rx_phase  = PS_LENL;
                    end
                    PS_LENL: begin
                        rx_length[7:0] = b;
                        rx_sum         = rx_sum ^ b;
                        rx_pos         = '0;
                        if (rx_length > FRAME_MAX) begin
                            rx_phase = PS_SYNC1;
                            r.ev     = EV_OVERSIZE;
                        end else begin
                            rx_phase = PS_CHECK;
                        end
                    end
                    PS_CHECK: begin
                        rx_check = b;
                        if (rx_length == 16'd0)
                            r.ev = close_frame();
                        else
                            rx_phase = PS_DATA;
                    end
                    PS_DATA: begin
                        rx_sum = rx_sum ^ b;
                        // A held frame keeps its payload; later bytes only feed the sum.
                        if (!hold_valid) begin
                            shadow_buf[rx_pos[7:0]]     = b;
                            shadow_written[rx_pos[7:0]] = 1'b1;
                        end
                        rx_pos = rx_pos + 9'd1;
                        if (rx_pos >= rx_length)
                            r.ev = close_frame();
                    end
                    default: rx_phase = PS_SYNC1;
                endcase
            end
            OP_READ: begin
                if (hold_valid && idx < hold_len)
                    r.rdata = shadow_buf[idx];
            end
            OP_RELEASE: hold_valid = 1'b0;
            default: ;
        endcase
        r.held  = hold_valid;
        r.htype = hold_valid ? hold_type : 8'h00;
        r.hlen  = hold_valid ? hold_len : 9'd0;
        r.good  = frames_ok;
        return r;
    endfunction

    // True unless the entry lies inside the held frame and was never written.
    function automatic bit entry_readable(input logic [7:0] idx);
        return !(hold_valid && idx < hold_len) || shadow_written[idx];
    endfunction

    // Offer one word after a random gap, hold it until taken, then log what is due.
    task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic [7:0] idx,
                             input logic typed, input frame_result_t want);
        int unsigned   gap;
        frame_result_t predicted;
        if (op == OP_READ)
            while (!entry_readable(idx))
                idx++;
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_rx_byte    <= b;
        s_read_index <= idx;
        do @(posedge aclk); while (!s_ready);
        predicted = parse_word(op, b, idx);
        status_due.push_back(typed ? want : predicted);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // Read the held payload, mostly inside the held length.
    task automatic send_read();
        logic [7:0] idx;
        if (hold_valid && hold_len != 9'd0 && $urandom_range(0, 3) != 0)
            idx = 8'($urandom_range(0, hold_len - 1));
        else
            idx = 8'($urandom);
        send_word(OP_READ, 8'($urandom), idx, 1'b0, NO_STATUS);
    endtask

    // Send one frame of the given length, possibly flawed, with reads,
    // releases and unused opcodes slipped in between its bytes now and then.
    task automatic send_frame(input int unsigned len, input frame_flaw_t flaw);
        logic [15:0]  flen;
        logic [7:0]   ftype;
        logic [7:0]   sum;
        logic [7:0]   pay;
        logic [7:0]   body [$];
        logic [7:0]   link [$];
        int unsigned  keep;
        int unsigned  side;
        flen  = len[15:0];
        ftype = 8'($urandom);
        sum   = ftype ^ flen[15:8] ^ flen[7:0];
        if (len <= FRAME_MAX) begin
            for (int i = 0; i < len; i++) begin
                pay = 8'($urandom);
                body.push_back(pay);
                sum = sum ^ pay;
            end
        end
        if (flaw == FLAW_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        link = '{SYNC_FIRST, SYNC_SECOND, ftype, flen[15:8], flen[7:0]};
        // An oversize frame is dropped after its length, so send nothing more.
        if (len <= FRAME_MAX) begin
            link.push_back(sum);
            link = {link, body};
        end
        if (flaw == FLAW_SYNC) begin
            link[1] = 8'($urandom);
            if (link[1] == SYNC_SECOND)
                link[1] = 8'h54;
        end
        keep = (flaw == FLAW_CUT) ? $urandom_range(1, link.size() - 1) : link.size();
        for (int i = 0; i < keep; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                side = $urandom_range(0, 9);
                if (side < 6)
                    send_read();
                else if (side < 9)
                    send_word(OP_RELEASE, 8'($urandom), 8'($urandom), 1'b0, NO_STATUS);
                else
                    send_word(OP_UNUSED, 8'($urandom), 8'($urandom), 1'b0, NO_STATUS);
            end
            send_word(OP_RX, link[i], 8'($urandom), 1'b0, NO_STATUS);
        end
    endtask

    // Result side: stall at random, then hold ready until a word is taken.
    initial begin : result_sink
        int unsigned stall;
        bit          calm;
        calm = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
        end
    end

    // Compare every word taken from the block with the oldest one due, and
    // count cycles in which neither side moves a word.
    always @(posedge aclk) begin : status_check
        frame_result_t due;
        if (!aresetn)
            quiet_cycles <= 0;
        else if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                report_mismatch("word with nothing due, event_status", m_event_status, 0);
            end else begin
                due = status_due.pop_front();
                if (m_event_status !== due.ev)
                    report_mismatch("event_status", m_event_status, due.ev);
                if (m_frame_held !== due.held)
                    report_mismatch("frame_held", m_frame_held, due.held);
                if (m_held_type !== due.htype)
                    report_mismatch("held_type", m_held_type, due.htype);
                if (m_held_length !== due.hlen)
                    report_mismatch("held_length", m_held_length, due.hlen);
                if (m_read_data !== due.rdata)
                    report_mismatch("read_data", m_read_data, due.rdata);
                if (m_good_frames !== due.good)
                    report_mismatch("good_frames", m_good_frames, due.good);
            end
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned pick;
        int unsigned len;
        frame_flaw_t flaw;

        // Predicted receiver starts from its reset state.
        rx_phase   = PS_SYNC1;
        rx_type    = '0;
        rx_length  = '0;
        rx_pos     = '0;
        rx_sum     = '0;
        rx_check   = '0;
        hold_valid = 1'b0;
        hold_type  = '0;
        hold_len   = '0;
        frames_ok  = '0;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_opcode     <= OP_RX;
        s_rx_byte    <= 8'h00;
        s_read_index <= 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Opening table: special cases and extremes.
        for (int i = 0; i < $size(OPENING_ROWS); i++)
            send_word(OPENING_ROWS[i].op, OPENING_ROWS[i].b, OPENING_ROWS[i].idx,
                      OPENING_ROWS[i].typed, OPENING_ROWS[i].want);

        // Free the buffer, fill it completely, read both ends, then go one past the limit.
        send_word(OP_RELEASE, 8'($urandom), 8'($urandom), 1'b0, NO_STATUS);
        send_frame(FRAME_MAX, FLAW_NONE);
        send_word(OP_READ, 8'($urandom), 8'h00, 1'b0, NO_STATUS);
        send_word(OP_READ, 8'($urandom), 8'hFF, 1'b0, NO_STATUS);
        send_frame(FRAME_MAX + 1, FLAW_NONE);

        // Mostly well-formed frames with short payloads, with some noise,
        // broken headers, cut frames, bad sums and oversize lengths mixed in.
        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 11) == 0)
                repeat ($urandom_range(1, 3))
                    send_word(OP_RX, 8'($urandom), 8'($urandom), 1'b0, NO_STATUS);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(0, 8);
            else if (pick < 90)
                len = $urandom_range(9, 40);
            else if (pick < 92)
                len = $urandom_range(41, FRAME_MAX);
            else if (pick < 96)
                len = FRAME_MAX + 1;
            else
                len = $urandom_range(FRAME_MAX + 2, 16'hFFFF);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                flaw = FLAW_NONE;
            else if (pick < 82)
                flaw = FLAW_SUM;
            else if (pick < 92)
                flaw = FLAW_CUT;
            else
                flaw = FLAW_SYNC;
            send_frame(len, flaw);
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 3)) send_read();
            if ($urandom_range(0, 1) == 1)
                send_word(OP_RELEASE, 8'($urandom), 8'($urandom), 1'b0, NO_STATUS);
        end
        s_valid <= 1'b0;

        // Drain: wait for every due word, then let the pipeline settle before the verdict.
        while (status_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/slfr_pkg.sv
rtl/core/slfr_parser.sv
rtl/core/sync_length_xor_frame_receiver.sv
bench/tb.sv
